@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the list checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(LBL, CLK, RST_N, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |-> (CONS)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(LBL, CLK, RST_N, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |=> (CONS)) \
    else $error("assertion failed");

`endif

@@ design/plc_pkg.sv @@
// ---------------------------------------------------------------------------
// plc_pkg
// Types, codes and sizes shared by the positional list modules.
// ---------------------------------------------------------------------------
package plc_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LEN_W    = 5;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_INS_AT    = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_BACK  = 3'd4;
  localparam logic [2:0] OP_DEL_AT    = 3'd5;
  localparam logic [2:0] OP_DISPLAY   = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DATA_W-1:0] element;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
  } mem_req_t;

  function automatic logic [LEN_W-1:0] len_of(input logic [CNT_W-1:0] c);
    logic [CMP_W-1:0] w;
    w = CMP_W'(c);
    return w[LEN_W-1:0];
  endfunction

endpackage

@@ design/plc_ram.sv @@
// ---------------------------------------------------------------------------
// plc_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module plc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/plc_ctrl.sv @@
// ---------------------------------------------------------------------------
// plc_ctrl
// Operation sequencer: decodes each operation, moves entries through the
// RAM one per cycle and drives the registered result channel.
// ---------------------------------------------------------------------------
module plc_ctrl import plc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  output mem_req_t          mem_req,
  input  logic [DATA_W-1:0] rd_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;
  localparam logic [2:0] S_DISP  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  end_r, end_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  wa_r, wa_nxt;
  logic              ins_r, ins_nxt;
  logic              rv_r, rv_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              in_take;
  logic              out_free;
  logic              is_full;
  logic              is_empty;
  logic              ins_pos_ok;
  logic              del_pos_ok;
  logic [CMP_W-1:0]  cnt_x;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  pos_idx;
  logic [IDX_W-1:0]  cnt_idx;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  sel_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cnt_x      = CMP_W'(count_r);
  assign pos_x      = CMP_W'(in_data.position);
  assign pos_m1     = pos_x - CMP_W'(1);
  assign cnt_m1     = count_r - CNT_W'(1);
  assign pos_idx    = pos_m1[IDX_W-1:0];
  assign cnt_idx    = count_r[IDX_W-1:0];
  assign last_idx   = cnt_m1[IDX_W-1:0];
  assign is_full    = (count_r >= CNT_W'(CAPACITY));
  assign is_empty   = (count_r == '0);
  assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
  assign del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    idx_nxt       = idx_r;
    wa_nxt        = wa_r;
    ins_nxt       = ins_r;
    rv_nxt        = 1'b0;
    value_nxt     = value_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    mem_req       = '0;
    sel_idx       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          value_nxt  = in_data.value;
          status_nxt = ST_OK;
          case (in_data.op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else if ((in_data.op == OP_INS_AT) && !ins_pos_ok) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end else begin
                if (in_data.op == OP_INS_FRONT) begin
                  sel_idx = '0;
                end else if (in_data.op == OP_INS_BACK) begin
                  sel_idx = cnt_idx;
                end else begin
                  sel_idx = pos_idx;
                end
                count_nxt = count_r + CNT_W'(1);
                idx_nxt   = sel_idx;
                ins_nxt   = 1'b1;
                ptr_nxt   = cnt_idx - IDX_W'(1);
                end_nxt   = sel_idx;
                state_nxt = (sel_idx == cnt_idx) ? S_PUT : S_SHIFT;
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else if ((in_data.op == OP_DEL_AT) && !del_pos_ok) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end else begin
                if (in_data.op == OP_DEL_FRONT) begin
                  sel_idx = '0;
                end else if (in_data.op == OP_DEL_BACK) begin
                  sel_idx = last_idx;
                end else begin
                  sel_idx = pos_idx;
                end
                count_nxt = cnt_m1;
                idx_nxt   = sel_idx;
                ins_nxt   = 1'b0;
                ptr_nxt   = sel_idx + IDX_W'(1);
                end_nxt   = last_idx;
                state_nxt = (sel_idx == last_idx) ? S_RESP : S_SHIFT;
              end
            end
            OP_DISPLAY: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                ptr_nxt         = '0;
                end_nxt         = last_idx;
                state_nxt       = S_DISP;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_SHIFT: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = ptr_r;
        mem_req.wr_en   = rv_r;
        mem_req.wr_addr = wa_r;
        mem_req.wr_data = rd_data;
        rv_nxt          = 1'b1;
        wa_nxt          = ins_r ? (ptr_r + IDX_W'(1)) : (ptr_r - IDX_W'(1));
        if (ptr_r == end_r) begin
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = ins_r ? (ptr_r - IDX_W'(1)) : (ptr_r + IDX_W'(1));
        end
      end
      S_DRAIN: begin
        mem_req.wr_en   = rv_r;
        mem_req.wr_addr = wa_r;
        mem_req.wr_data = rd_data;
        state_nxt       = ins_r ? S_PUT : S_RESP;
      end
      S_PUT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = idx_r;
        mem_req.wr_data = value_r;
        state_nxt       = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_nxt.status  = status_r;
          out_nxt.element = '0;
          out_nxt.length  = len_of(count_r);
          out_nxt.last    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_DISP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_nxt.status  = ST_OK;
          out_nxt.element = $signed(rd_data);
          out_nxt.length  = len_of(count_r);
          out_nxt.last    = (ptr_r == end_r);
          if (ptr_r == end_r) begin
            state_nxt = S_IDLE;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ptr_r + IDX_W'(1);
            ptr_nxt         = ptr_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    end_r    <= end_nxt;
    idx_r    <= idx_nxt;
    wa_r     <= wa_nxt;
    ins_r    <= ins_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

endmodule

@@ design/positional_circular_list.sv @@
// ---------------------------------------------------------------------------
// positional_circular_list
// Bounded ordered list of signed 32-bit values held in a single RAM.
// ---------------------------------------------------------------------------
// Each transfer on the input channel is one list operation; the block takes
// one operation at a time and holds in_stall high until its results are
// queued. An operation that writes no entry (every error case, an unused
// opcode and a delete at the tail) goes straight to the response state, and
// an insert that shifts nothing writes its value in the put state first.
// Inserts and deletes that shift entries move them through the shift and
// drain states; an insert then writes its value in the put state, before
// the response. Display of n entries reads the first entry, then delivers
// one result per cycle when the output is not stalled. The single RAM
// reads one entry and writes one entry per cycle. The RAM needs no clearing
// after reset; only entries below the current length are read.
module positional_circular_list import plc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rd_data;

  plc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  plc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

endmodule

@@ design/plc_checker.sv @@
// ---------------------------------------------------------------------------
// plc_checker
// Port-level checks on the positional list, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module plc_checker import plc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `ASSERT_NXT(a_out_valid_held, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_NXT(a_out_data_held, clk, rst_n, out_valid && out_stall, $stable(out_data))
  `ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
  `ASSERT_IMP(a_error_single, clk, rst_n, out_valid && (out_data.status != ST_OK), out_data.last && (out_data.element == '0))
  `ASSERT_IMP(a_full_length, clk, rst_n, out_valid && (out_data.status == ST_FULL), out_data.length == len_of(CNT_W'(CAPACITY)))

endmodule

bind positional_circular_list plc_checker u_plc_checker (.*);
